### sv/range_normalize_colormap_core_macros.svh
// ----------------------------------------------------------------------------
// Range normalise colormap: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_NORMALIZE_COLORMAP_CORE_MACROS_SVH
`define RANGE_NORMALIZE_COLORMAP_CORE_MACROS_SVH

// condition holds at every edge
`define RNC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the trigger
`define RNC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/rnc_pkg.sv
// ----------------------------------------------------------------------------
// Range normalise colormap: package
// Shared widths, codes and payload types.
// ----------------------------------------------------------------------------
package rnc_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int LEVEL_BITS  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_MAP     = 2'd2;

    localparam logic [1:0] CLASS_FINITE  = 2'd0;
    localparam logic [1:0] CLASS_POS_INF = 2'd1;
    localparam logic [1:0] CLASS_NEG_INF = 2'd2;
    localparam logic [1:0] CLASS_NAN     = 2'd3;

    localparam logic REG_ANCHOR = 1'b0;
    localparam logic REG_COLOR  = 1'b1;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = {LEVEL_BITS{1'b0}};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LEVEL_BITS-1:0]         level_t;

    typedef struct packed {
        logic [1:0] opcode;
        sample_t    sample;
        logic [1:0] sample_class;
    } item_t;

    typedef struct packed {
        level_t gray_level;
        level_t red;
        level_t green;
        level_t blue;
    } result_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_MEASURE,
        CMD_MAP,
        CMD_FIXED
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        sample_t   sample;
        level_t    level;
    } cmd_t;

    typedef struct packed {
        logic anchor_at_zero;
        logic palette_on;
    } cfg_t;

endpackage

### sv/range_normalize_colormap_core.sv
// ----------------------------------------------------------------------------
// Range normalise colormap: top level
// Min/max normalisation of fixed-point samples to 8-bit levels, red-blue map.
// ----------------------------------------------------------------------------
// Input beats enter on item/push/full: opcode clear, measure or map, a signed
// Q16.16 sample and its class. Clear and measure beats give no result; each
// map beat gives one result beat on result/empty/pop (level and rgb).
// Configuration (anchor_at_zero at 0x0, palette_on at 0x4) goes through the
// APB port; the user must write it only while the block is idle, which the
// block does not enforce. A non-finite or out-of-range map passes the front
// register, queue and level register to the result register. Clear and
// measure beats drain at one per cycle while the back end is idle; a divided
// map holds the back end for a doubling and an add step per quotient bit of
// the restoring divider, plus set-up, rounding and result load. The front
// end keeps accepting into a command queue of QUEUE_DEPTH entries while the
// back end divides or the result waits; full rises once the queue is full
// and the front register holds a command too. A stalled result holds on the
// port and the back end waits behind it. Reset clears the range, the queue
// and the result register; anchor_at_zero comes up as 1 and palette_on as 0.
// ----------------------------------------------------------------------------
module range_normalize_colormap_core #(
    parameter int QUEUE_DEPTH = rnc_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rnc_pkg::item_t                  item,
    input  logic                            push,
    output logic                            full,
    output rnc_pkg::result_t                result,
    output logic                            empty,
    input  logic                            pop,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rnc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [rnc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [rnc_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready
);

    rnc_pkg::cfg_t cfg_reg;
    rnc_pkg::cfg_t cfg_next;
    logic          wr_en;
    rnc_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          q_full;
    rnc_pkg::cmd_t q_cmd;
    logic          q_empty;
    logic          q_pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                rnc_pkg::REG_ANCHOR: cfg_next.anchor_at_zero = pwdata[0];
                default:             cfg_next.palette_on     = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            rnc_pkg::REG_ANCHOR:
                prdata = {{(rnc_pkg::DATA_BITS - 1){1'b0}}, cfg_reg.anchor_at_zero};
            default:
                prdata = {{(rnc_pkg::DATA_BITS - 1){1'b0}}, cfg_reg.palette_on};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.anchor_at_zero <= 1'b1;
            cfg_reg.palette_on     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rnc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_full  (q_full)
    );

    rnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_cmd),
        .empty (q_empty)
    );

    rnc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (q_pop),
        .cfg       (cfg_reg),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### sv/rnc_front.sv
// ----------------------------------------------------------------------------
// Range normalise colormap: front end
// Accepts input beats, drops those without effect and classifies the rest.
// ----------------------------------------------------------------------------
module rnc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  rnc_pkg::item_t item,
    input  logic           push,
    output logic           full,
    output rnc_pkg::cmd_t  cmd,
    output logic           cmd_valid,
    input  logic           cmd_full
);

    logic          valid_reg;
    logic          valid_next;
    rnc_pkg::cmd_t cmd_reg;
    rnc_pkg::cmd_t cmd_next;
    logic          keep;
    rnc_pkg::cmd_t decoded;
    logic          accept;

    assign full      = valid_reg && cmd_full;
    assign accept    = push && !full;
    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

    always_comb
    begin
        decoded.kind   = rnc_pkg::CMD_CLEAR;
        decoded.sample = item.sample;
        decoded.level  = rnc_pkg::LEVEL_MIN;
        keep           = 1'b0;
        case (item.opcode)
            rnc_pkg::OP_CLEAR:
            begin
                keep = 1'b1;
            end
            rnc_pkg::OP_MEASURE:
            begin
                decoded.kind = rnc_pkg::CMD_MEASURE;
                keep         = (item.sample_class == rnc_pkg::CLASS_FINITE);
            end
            rnc_pkg::OP_MAP:
            begin
                keep = 1'b1;
                if (item.sample_class == rnc_pkg::CLASS_FINITE)
                begin
                    decoded.kind = rnc_pkg::CMD_MAP;
                end
                else
                begin
                    decoded.kind  = rnc_pkg::CMD_FIXED;
                    decoded.level = (item.sample_class == rnc_pkg::CLASS_POS_INF) ?
                                    rnc_pkg::LEVEL_MAX : rnc_pkg::LEVEL_MIN;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && !cmd_full)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = keep;
            cmd_next   = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

### sv/rnc_queue.sv
// ----------------------------------------------------------------------------
// Range normalise colormap: command queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
`include "range_normalize_colormap_core_macros.svh"

module rnc_queue #(
    parameter int DEPTH = rnc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rnc_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output rnc_pkg::cmd_t rdata,
    output logic          empty
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    rnc_pkg::cmd_t         mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  wr_en;
    logic                  rd_en;

    assign full  = (count_reg == COUNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `RNC_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_BITS'(DEPTH), "queue count beyond depth")
    `RNC_ASSERT_NEXT(a_push_grows, wr_en && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")
    `RNC_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

### sv/rnc_back.sv
// ----------------------------------------------------------------------------
// Range normalise colormap: back end
// Holds the measured range, runs the level divider and the result register.
// ----------------------------------------------------------------------------
`include "range_normalize_colormap_core_macros.svh"

module rnc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rnc_pkg::cmd_t    cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  rnc_pkg::cfg_t    cfg,
    output rnc_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    localparam int SB       = rnc_pkg::SAMPLE_BITS;
    localparam int LB       = rnc_pkg::LEVEL_BITS;
    localparam int ITERS    = rnc_pkg::LEVEL_BITS;
    localparam int ITER_BITS = $clog2(ITERS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DBL,
        S_ADD,
        S_ROUND,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    rnc_pkg::sample_t   low_reg, low_next;
    rnc_pkg::sample_t   high_reg, high_next;
    logic               seen_reg, seen_next;
    logic [SB-1:0]      d_reg, d_next;
    logic [SB-1:0]      r_reg, r_next;
    logic [SB-1:0]      rem_reg, rem_next;
    logic [LB:0]        q_reg, q_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    rnc_pkg::level_t    level_reg, level_next;
    rnc_pkg::result_t   out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    rnc_pkg::sample_t   x;
    logic               out_free;
    logic [SB:0]        dbl;
    logic [SB:0]        sum;
    logic               dbl_ge;
    logic               sum_ge;
    logic [LB:0]        q_fin;
    logic               map_zero;
    logic               map_full;
    logic [SB-1:0]      d_sel;
    logic [SB-1:0]      r_sel;
    logic               busy;

    assign x        = cmd.sample;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign dbl      = {rem_reg, 1'b0};
    assign sum      = {1'b0, rem_reg} + {1'b0, d_reg};
    assign dbl_ge   = (dbl >= {1'b0, r_reg});
    assign sum_ge   = (sum >= {1'b0, r_reg});
    assign q_fin    = q_reg + (LB + 1)'(dbl_ge);
    assign busy     = (state_reg == S_DBL) || (state_reg == S_ADD) || (state_reg == S_ROUND);

    always_comb
    begin
        if (cfg.anchor_at_zero)
        begin
            map_zero = (high_reg <= 0) || (x <= 0);
            map_full = (x >= high_reg);
            d_sel    = SB'(x);
            r_sel    = SB'(high_reg);
        end
        else
        begin
            map_zero = !seen_reg || (high_reg <= low_reg) || (x <= low_reg);
            map_full = (x >= high_reg);
            d_sel    = SB'(x - low_reg);
            r_sel    = SB'(high_reg - low_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        seen_next      = seen_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        iter_next      = iter_reg;
        level_next     = level_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        rnc_pkg::CMD_CLEAR:
                        begin
                            low_next  = '0;
                            high_next = '0;
                            seen_next = 1'b0;
                        end
                        rnc_pkg::CMD_MEASURE:
                        begin
                            if (cfg.anchor_at_zero)
                            begin
                                if (x > high_reg)
                                begin
                                    high_next = x;
                                end
                            end
                            else if (!seen_reg)
                            begin
                                low_next  = x;
                                high_next = x;
                                seen_next = 1'b1;
                            end
                            else
                            begin
                                if (x < low_reg)
                                begin
                                    low_next = x;
                                end
                                if (x > high_reg)
                                begin
                                    high_next = x;
                                end
                            end
                        end
                        rnc_pkg::CMD_FIXED:
                        begin
                            level_next = cmd.level;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            if (map_zero)
                            begin
                                level_next = rnc_pkg::LEVEL_MIN;
                                state_next = S_OUT;
                            end
                            else if (map_full)
                            begin
                                level_next = rnc_pkg::LEVEL_MAX;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                d_next     = d_sel;
                                r_next     = r_sel;
                                rem_next   = '0;
                                q_next     = '0;
                                iter_next  = '0;
                                state_next = S_DBL;
                            end
                        end
                    endcase
                end
            end
            S_DBL:
            begin
                q_next = {q_reg[LB-1:0], dbl_ge};
                if (dbl_ge)
                begin
                    rem_next = SB'(dbl - {1'b0, r_reg});
                end
                else
                begin
                    rem_next = SB'(dbl);
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                q_next = q_reg + (LB + 1)'(sum_ge);
                if (sum_ge)
                begin
                    rem_next = SB'(sum - {1'b0, r_reg});
                end
                else
                begin
                    rem_next = SB'(sum);
                end
                if (iter_reg == ITER_BITS'(ITERS - 1))
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_DBL;
                end
            end
            S_ROUND:
            begin
                level_next = q_fin[LB] ? rnc_pkg::LEVEL_MAX : q_fin[LB-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next.gray_level = level_reg;
                    out_next.green      = '0;
                    if (cfg.palette_on && (level_reg != rnc_pkg::LEVEL_MIN))
                    begin
                        out_next.red  = rnc_pkg::LEVEL_MAX - level_reg;
                        out_next.blue = level_reg;
                    end
                    else
                    begin
                        out_next.red  = '0;
                        out_next.blue = '0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= '0;
            high_reg      <= '0;
            seen_reg      <= 1'b0;
            d_reg         <= '0;
            r_reg         <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            iter_reg      <= '0;
            level_reg     <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            seen_reg      <= seen_next;
            d_reg         <= d_next;
            r_reg         <= r_next;
            rem_reg       <= rem_next;
            q_reg         <= q_next;
            iter_reg      <= iter_next;
            level_reg     <= level_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RNC_ASSERT_ALWAYS(a_range_order, low_reg <= high_reg, "range bounds crossed")
    `RNC_ASSERT_ALWAYS(a_rem_bound, !busy || (rem_reg < r_reg), "divider remainder out of range")
    `RNC_ASSERT_NEXT(a_hold_result, (state_reg == S_OUT) && out_valid_reg && !pop, state_reg == S_OUT, "result overwritten while stalled")

endmodule
